/* hdl/prqs_pkg.sv */
// ============================================================================
// prqs_pkg
// Shared types and constants for the process ready queue scheduler: the
// packed task entry, the request and response items and the register map.
// ============================================================================
`default_nettype none

package prqs_pkg;

    // Ready queue geometry.
    localparam int QUEUE_DEPTH = 16;
    localparam int ADDR_W      = $clog2(QUEUE_DEPTH);
    localparam int COUNT_W     = $clog2(QUEUE_DEPTH + 1);
    localparam int QCOUNT_W    = 5;

    // Configuration port.
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    localparam logic REG_POLICY  = 1'b0;
    localparam logic REG_QUANTUM = 1'b1;

    localparam logic [15:0] QUANTUM_RESET = 16'd4;

    // Request kinds.
    localparam logic REQ_ARRIVAL = 1'b0;
    localparam logic REQ_TICK    = 1'b1;

    typedef enum logic [1:0] {
        POLICY_FCFS = 2'd0,
        POLICY_SJF  = 2'd1,
        POLICY_PRIO = 2'd2,
        POLICY_RR   = 2'd3
    } policy_t;

    typedef struct packed {
        logic [7:0]  id;
        logic [7:0]  priority_num;
        logic [15:0] burst;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef struct packed {
        logic        req_type;
        logic [7:0]  arrive_id;
        logic [15:0] arrive_burst;
        logic [7:0]  arrive_priority;
    } req_t;

    typedef struct packed {
        logic                arrival_status;
        logic                busy_res;
        logic [7:0]          running_id;
        logic                finished;
        logic [7:0]          finished_id;
        logic [QCOUNT_W-1:0] queue_count;
    } rsp_t;

endpackage

`default_nettype wire

/* hdl/prqs_req_if.sv */
// ============================================================================
// prqs_req_if
// Valid/ready channel that carries one request item into the scheduler.
// ============================================================================
`default_nettype none

interface prqs_req_if
    import prqs_pkg::*;
;
    logic valid;
    logic ready;
    req_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

/* hdl/prqs_rsp_if.sv */
// ============================================================================
// prqs_rsp_if
// Valid/ready channel that carries one response item out of the scheduler.
// ============================================================================
`default_nettype none

interface prqs_rsp_if
    import prqs_pkg::*;
;
    logic valid;
    logic ready;
    rsp_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

/* hdl/prqs_ram.sv */
// ============================================================================
// prqs_ram
// Generic simple dual-port RAM: one write port, one read port with the read
// data registered. Contents are undefined until written.
// ============================================================================
`default_nettype none

module prqs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

/* hdl/process_ready_queue_scheduler.sv */
// Timing: an arrival is answered from the output register in the cycle after it
// is taken. A tick goes straight to the run step when a task is already running;
// else it first scans the queue (every waiting entry for shortest job and priority,
// the head otherwise) and then shifts the entries behind the picked one forward.
// Throughput: one item at a time; the next is taken once the result is out.
// Reset (rst_n, async low) empties the queue and stops the running task; the
// queue RAM itself is not cleared, since only entries below the count are read.
// ============================================================================
// process_ready_queue_scheduler
// Single-processor task scheduler with an ordered ready queue held in RAM,
// serving first come, shortest job, priority and round-robin policies.
// ============================================================================
`default_nettype none

module process_ready_queue_scheduler
    import prqs_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    prqs_req_if.sink                req,
    prqs_rsp_if.source              rsp,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [PDATA_W-1:0] pwdata,
    output logic      [PDATA_W-1:0] prdata,
    output logic                    pready
);

    // ------------------------------------------------------------------------
    // Configuration registers. The register is chosen by address bit 2, so
    // every byte address of the port maps onto one of the two registers.
    // ------------------------------------------------------------------------
    policy_t     policy_reg;
    logic [15:0] quantum_reg;
    logic        cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            policy_reg  <= POLICY_FCFS;
            quantum_reg <= QUANTUM_RESET;
        end
        else if (cfg_write)
        begin
            unique case (paddr[2])
                REG_POLICY:  policy_reg  <= policy_t'(pwdata[1:0]);
                REG_QUANTUM: quantum_reg <= pwdata[15:0];
                default:     policy_reg  <= policy_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_POLICY:  prdata = PDATA_W'(policy_reg);
            REG_QUANTUM: prdata = PDATA_W'(quantum_reg);
            default:     prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------------
    // Ready queue RAM. Entries 0 .. count-1 hold the waiting tasks in arrival
    // order. During a scan and a shift the read pointer walks forward one
    // address per cycle, and a shift writes each returned entry one address
    // lower, so a read and a write never hit the same address in one cycle.
    // ------------------------------------------------------------------------
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    entry_t            ram_wdata;
    logic [ADDR_W-1:0] ram_raddr;
    entry_t            ram_rdata;

    prqs_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // ------------------------------------------------------------------------
    // Sequencer.
    // IDLE : takes an item. An arrival is appended, or refused when full, and
    //        answered at once. A tick requeues a spent round-robin task and
    //        decides whether a new task must be picked.
    // SCAN : reads entries from the head and keeps the earliest minimum. For
    //        first come and round robin only the head is read.
    // SHIFT: moves every entry behind the picked one a place forward.
    // RUN  : runs one unit of the running task and issues the result.
    // ------------------------------------------------------------------------
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SHIFT,
        ST_RUN
    } state_t;

    state_t             state_reg,   state_next;
    logic [COUNT_W-1:0] count_reg,   count_next;
    logic               rv_reg,      rv_next;
    entry_t             run_reg,     run_next;
    logic [15:0]        slice_reg,   slice_next;
    logic [COUNT_W-1:0] ptr_reg,     ptr_next;
    logic [COUNT_W-1:0] lim_reg,     lim_next;
    logic               pend_reg,    pend_next;
    logic [ADDR_W-1:0]  tag_reg,     tag_next;
    entry_t             best_reg,    best_next;
    logic [ADDR_W-1:0]  bidx_reg,    bidx_next;
    logic               ovalid_reg,  ovalid_next;
    rsp_t               opay_reg,    opay_next;

    logic               out_free;
    logic               accept;
    logic [COUNT_W:0]   occupied;
    logic               requeue;
    logic               rv_after;
    logic [COUNT_W-1:0] count_after;
    logic               issue;
    logic               take;
    logic [ADDR_W-1:0]  bidx_sel;
    logic [15:0]        rem;
    entry_t             new_entry;

    assign out_free  = !ovalid_reg || rsp.ready;
    assign req.ready = (state_reg == ST_IDLE) && out_free;
    assign accept    = req.valid && req.ready;
    assign occupied  = {1'b0, count_reg} + (COUNT_W + 1)'(rv_reg);
    assign issue     = ptr_reg < lim_reg;

    assign rsp.valid   = ovalid_reg;
    assign rsp.payload = opay_reg;

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        rv_next     = rv_reg;
        run_next    = run_reg;
        slice_next  = slice_reg;
        ptr_next    = ptr_reg;
        lim_next    = lim_reg;
        pend_next   = 1'b0;
        tag_next    = tag_reg;
        best_next   = best_reg;
        bidx_next   = bidx_reg;
        ovalid_next = ovalid_reg && !rsp.ready;
        opay_next   = opay_reg;

        ram_we      = 1'b0;
        ram_waddr   = count_reg[ADDR_W-1:0];
        ram_wdata   = run_reg;
        ram_raddr   = ptr_reg[ADDR_W-1:0];

        requeue     = 1'b0;
        rv_after    = rv_reg;
        count_after = count_reg;
        take        = 1'b0;
        bidx_sel    = bidx_reg;
        rem         = run_reg.burst;

        new_entry.id           = req.payload.arrive_id;
        new_entry.priority_num = req.payload.arrive_priority;
        new_entry.burst        = (req.payload.arrive_burst == 16'd0) ? 16'd1
                                                                     : req.payload.arrive_burst;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (req.payload.req_type == REQ_ARRIVAL)
                    begin
                        opay_next = '0;
                        if (occupied >= (COUNT_W + 1)'(QUEUE_DEPTH))
                        begin
                            opay_next.arrival_status = 1'b1;
                            opay_next.queue_count    = QCOUNT_W'(count_reg);
                        end
                        else
                        begin
                            ram_we                = 1'b1;
                            ram_wdata             = new_entry;
                            count_next            = count_reg + 1'b1;
                            opay_next.queue_count = QCOUNT_W'(count_reg + 1'b1);
                        end
                        ovalid_next = 1'b1;
                    end
                    else
                    begin
                        // A spent round-robin task goes back to the tail; the
                        // place it held in the depth keeps this from overflowing.
                        requeue = (policy_reg == POLICY_RR) && rv_reg && (slice_reg == 16'd0);
                        if (requeue)
                        begin
                            ram_we      = 1'b1;
                            ram_wdata   = run_reg;
                            rv_after    = 1'b0;
                            count_after = count_reg + 1'b1;
                        end
                        rv_next    = rv_after;
                        count_next = count_after;
                        if (!rv_after && (count_after != '0))
                        begin
                            ptr_next = '0;
                            if ((policy_reg == POLICY_SJF) || (policy_reg == POLICY_PRIO))
                            begin
                                lim_next = count_after;
                            end
                            else
                            begin
                                lim_next = COUNT_W'(1);
                            end
                            state_next = ST_SCAN;
                        end
                        else
                        begin
                            state_next = ST_RUN;
                        end
                    end
                end
            end

            ST_SCAN:
            begin
                if (issue)
                begin
                    pend_next = 1'b1;
                    tag_next  = ptr_reg[ADDR_W-1:0];
                    ptr_next  = ptr_reg + 1'b1;
                end
                if (pend_reg)
                begin
                    // Strict compare: a tie keeps the earlier entry.
                    if (tag_reg == '0)
                    begin
                        take = 1'b1;
                    end
                    else if (policy_reg == POLICY_SJF)
                    begin
                        take = ram_rdata.burst < best_reg.burst;
                    end
                    else
                    begin
                        take = ram_rdata.priority_num < best_reg.priority_num;
                    end
                    if (take)
                    begin
                        best_next = ram_rdata;
                        bidx_sel  = tag_reg;
                    end
                    bidx_next = bidx_sel;
                    if (COUNT_W'(tag_reg) == (lim_reg - 1'b1))
                    begin
                        ptr_next   = COUNT_W'(bidx_sel) + 1'b1;
                        lim_next   = count_reg;
                        pend_next  = 1'b0;
                        state_next = ST_SHIFT;
                    end
                end
            end

            ST_SHIFT:
            begin
                if (pend_reg)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = tag_reg - 1'b1;
                    ram_wdata = ram_rdata;
                end
                if (issue)
                begin
                    pend_next = 1'b1;
                    tag_next  = ptr_reg[ADDR_W-1:0];
                    ptr_next  = ptr_reg + 1'b1;
                end
                else if (!pend_reg)
                begin
                    count_next = count_reg - 1'b1;
                    run_next   = best_reg;
                    rv_next    = 1'b1;
                    slice_next = (quantum_reg == 16'd0) ? 16'd1 : quantum_reg;
                    state_next = ST_RUN;
                end
            end

            ST_RUN:
            begin
                if (out_free)
                begin
                    opay_next             = '0;
                    opay_next.queue_count = QCOUNT_W'(count_reg);
                    if (rv_reg)
                    begin
                        rem = (run_reg.burst != 16'd0) ? (run_reg.burst - 16'd1) : 16'd0;
                        opay_next.busy_res   = 1'b1;
                        opay_next.running_id = run_reg.id;
                        run_next.burst       = rem;
                        if (slice_reg != 16'd0)
                        begin
                            slice_next = slice_reg - 16'd1;
                        end
                        if (rem == 16'd0)
                        begin
                            opay_next.finished    = 1'b1;
                            opay_next.finished_id = run_reg.id;
                            rv_next               = 1'b0;
                        end
                    end
                    ovalid_next = 1'b1;
                    state_next  = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            count_reg  <= '0;
            rv_reg     <= 1'b0;
            run_reg    <= '0;
            slice_reg  <= '0;
            ptr_reg    <= '0;
            lim_reg    <= '0;
            pend_reg   <= 1'b0;
            ovalid_reg <= 1'b0;
            opay_reg   <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            rv_reg     <= rv_next;
            run_reg    <= run_next;
            slice_reg  <= slice_next;
            ptr_reg    <= ptr_next;
            lim_reg    <= lim_next;
            pend_reg   <= pend_next;
            ovalid_reg <= ovalid_next;
            opay_reg   <= opay_next;
        end
    end

    // Payload registers need no reset.
    always_ff @(posedge clk)
    begin
        tag_reg  <= tag_next;
        best_reg <= best_next;
        bidx_reg <= bidx_next;
    end

`ifndef SYNTHESIS
    // Waiting tasks plus the running task never exceed the depth.
    assert property (@(posedge clk) disable iff (!rst_n)
        ({1'b0, count_reg} + (COUNT_W + 1)'(rv_reg)) <= (COUNT_W + 1)'(QUEUE_DEPTH))
    else $error("ready queue occupancy exceeds its depth");

    // A scan only reads; the queue must not change under it.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> !ram_we)
    else $error("queue RAM written during a scan");

    // The run step without a running task only happens on an empty queue.
    assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_RUN) && !rv_reg) |-> (count_reg == '0))
    else $error("idle tick with tasks waiting");

    // A completion is always reported on a tick that ran a task.
    assert property (@(posedge clk) disable iff (!rst_n)
        (ovalid_reg && opay_reg.finished) |->
            (opay_reg.busy_res && (opay_reg.finished_id == opay_reg.running_id)))
    else $error("finish reported without a matching busy tick");

    // A shift ends with the picked task running.
    assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_SHIFT) && (state_next == ST_RUN)) |=> rv_reg)
    else $error("selection finished without a running task");
`endif

endmodule

`default_nettype wire

/* bench/tb.sv */
`timescale 1ns / 100ps
// ============================================================================
// tb
// Self-checking bench for the process ready queue scheduler. A directed table
// covers the corner cases, then random phases run each scheduling policy with
// random idling on both channels. Responses are checked against a predictor.
// ============================================================================

module tb;

    import prqs_pkg::*;

    // Hard stop in clock cycles.
    localparam int CYCLE_LIMIT = 400000;
    localparam int MAX_WAIT    = 18;
    localparam int PHASES      = 6;
    localparam int PHASE_ITEMS = 130;
    localparam int CHUNK_ITEMS = 24;

    // One row of the directed table: either a register write or a request item,
    // optionally with the response typed in by hand.
    typedef struct {
        bit          is_write;
        logic        reg_sel;
        logic [31:0] wdata;
        req_t        item;
        bit          known;
        rsp_t        known_rsp;
    } stim_row_t;

    logic               clk;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    prqs_req_if req_ch ();
    prqs_rsp_if rsp_ch ();

    process_ready_queue_scheduler u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req_ch),
        .rsp     (rsp_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // ------------------------------------------------------------------------
    // Predictor state: a private copy of the ready queue, the task on the
    // processor, its time slice and the two registers.
    // ------------------------------------------------------------------------
    entry_t      ready_tasks [QUEUE_DEPTH];
    int          waiting_n   = 0;
    bit          cpu_busy    = 1'b0;
    entry_t      cpu_task    = '0;
    logic [15:0] slice_cnt   = '0;
    policy_t     cur_policy  = POLICY_FCFS;
    logic [15:0] cur_quantum = QUANTUM_RESET;

    // Responses still owed by the block, oldest first.
    rsp_t        due_responses [$];
    int          bad_responses = 0;

    // Knobs for the stimulus and the response sink, and the watchdog cycle counter.
    bit          no_gaps       = 1'b0;
    int          hold_request  = 0;
    int          arrival_pct   = 50;
    longint      cycle_count   = 0;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d responses outstanding",
                     cycle_count, due_responses.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Predictor. Computes the response of one accepted item and advances the
    // private scheduler state.
    // ------------------------------------------------------------------------
    function automatic rsp_t schedule_step(input req_t r);
        rsp_t        o;
        int          best;
        logic [15:0] burst;
        o = '0;
        if (r.req_type == REQ_ARRIVAL)
        begin
            // A zero burst still costs one tick.
            burst = (r.arrive_burst == 16'd0) ? 16'd1 : r.arrive_burst;
            // The running task holds one place of the depth.
            if (waiting_n + int'(cpu_busy) >= QUEUE_DEPTH)
                o.arrival_status = 1'b1;
            else
            begin
                ready_tasks[waiting_n] = '{id: r.arrive_id, priority_num: r.arrive_priority,
                                           burst: burst};
                waiting_n++;
            end
        end
        else
        begin
            // Round robin sends a task whose slice is spent to the tail.
            if (cur_policy == POLICY_RR && cpu_busy && slice_cnt == 16'd0)
            begin
                if (waiting_n < QUEUE_DEPTH)
                begin
                    ready_tasks[waiting_n] = cpu_task;
                    waiting_n++;
                end
                cpu_busy = 1'b0;
            end
            if (!cpu_busy && waiting_n > 0)
            begin
                // Strict less-than keeps the earliest entry on a tie.
                best = 0;
                for (int i = 1; i < waiting_n; i++)
                begin
                    if (cur_policy == POLICY_SJF && ready_tasks[i].burst < ready_tasks[best].burst)
                        best = i;
                    if (cur_policy == POLICY_PRIO &&
                        ready_tasks[i].priority_num < ready_tasks[best].priority_num)
                        best = i;
                end
                cpu_task = ready_tasks[best];
                for (int i = best; i < waiting_n - 1; i++)
                    ready_tasks[i] = ready_tasks[i + 1];
                waiting_n--;
                cpu_busy  = 1'b1;
                slice_cnt = (cur_quantum == 16'd0) ? 16'd1 : cur_quantum;
            end
            if (cpu_busy)
            begin
                o.busy_res   = 1'b1;
                o.running_id = cpu_task.id;
                if (cpu_task.burst != 16'd0)
                    cpu_task.burst--;
                // The slice counts down in every mode, only round robin acts on it.
                if (slice_cnt != 16'd0)
                    slice_cnt--;
                if (cpu_task.burst == 16'd0)
                begin
                    o.finished    = 1'b1;
                    o.finished_id = cpu_task.id;
                    cpu_busy      = 1'b0;
                end
            end
        end
        o.queue_count = QCOUNT_W'(waiting_n);
        return o;
    endfunction

    // ------------------------------------------------------------------------
    // Directed table builders.
    // ------------------------------------------------------------------------
    function automatic stim_row_t arrive(input logic [7:0] id, input logic [15:0] burst,
                                         input logic [7:0] prio);
        stim_row_t r;
        r = '{default: '0};
        r.item = '{req_type: REQ_ARRIVAL, arrive_id: id, arrive_burst: burst,
                   arrive_priority: prio};
        return r;
    endfunction

    function automatic stim_row_t tick_row();
        stim_row_t r;
        r = '{default: '0};
        r.item.req_type = REQ_TICK;
        return r;
    endfunction

    function automatic stim_row_t reg_write(input logic sel, input logic [31:0] value);
        stim_row_t r;
        r = '{default: '0};
        r.is_write = 1'b1;
        r.reg_sel  = sel;
        r.wdata    = value;
        return r;
    endfunction

    function automatic stim_row_t with_rsp(input stim_row_t r, input rsp_t e);
        r.known     = 1'b1;
        r.known_rsp = e;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Channel and register drivers. All but an idle drain_responses leave the caller
    // just after a rising edge, so the next driver starts in a fresh time step.
    // ------------------------------------------------------------------------

    // Offers one item after a random gap and books its expected response.
    task automatic issue_request(input req_t item, input bit known, input rsp_t known_rsp);
        int   gap;
        rsp_t predicted;
        gap = no_gaps ? 0 : $urandom_range(0, MAX_WAIT);
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        // valid stays high across back-to-back items.
        req_ch.valid   <= 1'b1;
        req_ch.payload <= item;
        do @(posedge clk); while (!req_ch.ready);
        predicted = schedule_step(item);
        due_responses.push_back(known ? known_rsp : predicted);
    endtask

    // Stops offering items and waits until every booked response has arrived.
    // Each item yields exactly one response, so the block is then idle.
    task automatic drain_responses();
        req_ch.valid <= 1'b0;
        while (due_responses.size() != 0)
            @(posedge clk);
    endtask

    // Setup cycle, then access cycle; the register is written at the edge that
    // sees pready in the access phase.
    task automatic apb_write(input logic sel, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {sel, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (sel == REG_POLICY)
            cur_policy = policy_t'(value[1:0]);
        else
            cur_quantum = value[15:0];
        @(posedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Response sink: random stalls, an optional long hold-off requested by the
    // stimulus, and the field-by-field check against the oldest expectation.
    // ------------------------------------------------------------------------
    initial
    begin : response_sink
        int   wait_cycles;
        rsp_t got;
        rsp_t want;
        rsp_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            wait_cycles  = no_gaps ? 0 : $urandom_range(0, MAX_WAIT);
            // The hold-off is counted here so the sender keeps offering items
            // while the block backs up behind the stalled response.
            wait_cycles += hold_request;
            hold_request = 0;
            if (wait_cycles > 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (wait_cycles) @(posedge clk);
            end
            rsp_ch.ready <= 1'b1;
            do @(posedge clk); while (!rsp_ch.valid);
            got = rsp_ch.payload;
            if (due_responses.size() == 0)
            begin
                if (bad_responses < 10)
                    $display("unexpected response: status=%0d busy=%0d run=%0h fin=%0d fin_id=%0h count=%0d",
                             got.arrival_status, got.busy_res, got.running_id,
                             got.finished, got.finished_id, got.queue_count);
                bad_responses++;
            end
            else
            begin
                want = due_responses.pop_front();
                if (got.arrival_status !== want.arrival_status ||
                    got.busy_res       !== want.busy_res       ||
                    got.running_id     !== want.running_id     ||
                    got.finished       !== want.finished       ||
                    got.finished_id    !== want.finished_id    ||
                    got.queue_count    !== want.queue_count)
                begin
                    if (bad_responses < 10)
                    begin
                        $display("mismatch: expected status=%0d busy=%0d run=%0h fin=%0d fin_id=%0h count=%0d",
                                 want.arrival_status, want.busy_res, want.running_id,
                                 want.finished, want.finished_id, want.queue_count);
                        $display("          actual   status=%0d busy=%0d run=%0h fin=%0d fin_id=%0h count=%0d",
                                 got.arrival_status, got.busy_res, got.running_id,
                                 got.finished, got.finished_id, got.queue_count);
                    end
                    bad_responses++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus.
    // ------------------------------------------------------------------------
    initial
    begin : stimulus
        stim_row_t   plan [$];
        policy_t     phase_policy [PHASES];
        logic [15:0] phase_quantum [PHASES];
        req_t        item;

        phase_policy  = '{POLICY_FCFS, POLICY_SJF, POLICY_PRIO, POLICY_RR, POLICY_RR, POLICY_RR};
        phase_quantum = '{16'd2, 16'd1, 16'hFFFF, 16'd1, 16'd6, 16'd3};

        rst_n          <= 1'b0;
        req_ch.valid   <= 1'b0;
        req_ch.payload <= '0;
        psel           <= 1'b0;
        penable        <= 1'b0;
        pwrite         <= 1'b0;
        paddr          <= '0;
        pwdata         <= '0;

        // Directed table. It starts in the reset setting: first come, quantum 4.
        // An idle tick with nothing queued answers with every field zero.
        plan.push_back(with_rsp(tick_row(), '{1'b0, 1'b0, 8'h00, 1'b0, 8'h00, 5'd0}));
        // A zero burst is taken as one tick, so the task ends on its first tick.
        plan.push_back(with_rsp(arrive(8'hFF, 16'h0000, 8'hFF),
                                '{1'b0, 1'b0, 8'h00, 1'b0, 8'h00, 5'd1}));
        plan.push_back(with_rsp(tick_row(), '{1'b0, 1'b1, 8'hFF, 1'b1, 8'hFF, 5'd0}));
        // Fill the queue to its depth. The bursts and priorities set up ties
        // for the shortest job and priority picks further down.
        plan.push_back(arrive(8'h01, 16'd2, 8'h50));
        plan.push_back(arrive(8'h02, 16'd1, 8'h60));
        plan.push_back(arrive(8'h03, 16'd4, 8'h20));
        plan.push_back(arrive(8'h04, 16'd1, 8'h20));
        plan.push_back(arrive(8'h10, 16'd3, 8'h90));
        plan.push_back(arrive(8'h00, 16'd3, 8'h00));
        plan.push_back(arrive(8'h11, 16'd5, 8'h00));
        plan.push_back(arrive(8'h12, 16'd2, 8'hFF));
        plan.push_back(arrive(8'h13, 16'd6, 8'h33));
        plan.push_back(arrive(8'h14, 16'd1, 8'h44));
        plan.push_back(arrive(8'h15, 16'd7, 8'h55));
        plan.push_back(arrive(8'h16, 16'd2, 8'h66));
        plan.push_back(arrive(8'h17, 16'd3, 8'h77));
        plan.push_back(arrive(8'h18, 16'd8, 8'h88));
        plan.push_back(arrive(8'h19, 16'd4, 8'h99));
        plan.push_back(with_rsp(arrive(8'h1A, 16'd6, 8'hAA),
                                '{1'b0, 1'b0, 8'h00, 1'b0, 8'h00, 5'd16}));
        // Full: the largest burst is refused and the queue is untouched.
        plan.push_back(with_rsp(arrive(8'h81, 16'hFFFF, 8'h7F),
                                '{1'b1, 1'b0, 8'h00, 1'b0, 8'h00, 5'd16}));
        // Zero quantum behaves as one, so round robin requeues after every tick.
        plan.push_back(reg_write(REG_QUANTUM, 32'd0));
        plan.push_back(reg_write(REG_POLICY, 32'(POLICY_RR)));
        plan.push_back(tick_row());
        plan.push_back(tick_row());
        // Shortest job: several one-tick tasks, the earliest must win.
        plan.push_back(reg_write(REG_POLICY, 32'(POLICY_SJF)));
        plan.push_back(reg_write(REG_QUANTUM, 32'hFFFF));
        plan.push_back(tick_row());
        // Priority: two tasks at priority zero, the earlier one is picked and keeps running.
        plan.push_back(reg_write(REG_POLICY, 32'(POLICY_PRIO)));
        plan.push_back(tick_row());
        plan.push_back(tick_row());

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i])
        begin
            if (plan[i].is_write)
            begin
                // Registers only change with no item in flight.
                drain_responses();
                apb_write(plan[i].reg_sel, plan[i].wdata);
            end
            else
                issue_request(plan[i].item, plan[i].known, plan[i].known_rsp);
        end

        // Random phases, one per setting. Large bursts would pin the processor
        // for tens of thousands of ticks outside round robin, so they are only
        // used in the last phase, where the quantum keeps the queue moving.
        for (int p = 0; p < PHASES; p++)
        begin
            drain_responses();
            apb_write(REG_POLICY, 32'(phase_policy[p]));
            apb_write(REG_QUANTUM, 32'(phase_quantum[p]));
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                // Each chunk picks a load level: draining, balanced or filling,
                // so the queue swings between empty and full. Some chunks run
                // with no idling on either side.
                if (n % CHUNK_ITEMS == 0)
                begin
                    case ($urandom_range(0, 2))
                        0:       arrival_pct = 15;
                        1:       arrival_pct = 50;
                        default: arrival_pct = 90;
                    endcase
                    no_gaps = ($urandom_range(0, 3) == 0);
                end
                // Long response stall while items keep coming in.
                if (p == 1 && n == 40)
                    hold_request = 300;
                // Pause the sender until the block has answered everything.
                if (p == 2 && n == 60)
                    drain_responses();
                item.req_type        = ($urandom_range(0, 99) < arrival_pct) ?
                                       REQ_ARRIVAL : REQ_TICK;
                item.arrive_id       = 8'($urandom_range(0, 255));
                item.arrive_priority = 8'($urandom_range(0, 255));
                if (p == PHASES - 1 && $urandom_range(0, 7) == 0)
                    item.arrive_burst = 16'($urandom_range(0, 65535));
                else
                    item.arrive_burst = 16'($urandom_range(0, 6));
                issue_request(item, 1'b0, '0);
            end
        end

        drain_responses();
        // Allow one worst-case tick for anything stray to show up.
        repeat (2 * QUEUE_DEPTH + 8) @(posedge clk);
        if (bad_responses == 0 && due_responses.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
